// File: sv/serial_dual_ring_fifo_with_error_counts_defines.svh
// Assertion helpers shared by the serial FIFO block.
`ifndef SERIAL_DUAL_RING_FIFO_WITH_ERROR_COUNTS_DEFINES_SVH
`define SERIAL_DUAL_RING_FIFO_WITH_ERROR_COUNTS_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SDRF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdrf: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SDRF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdrf: next-cycle check failed");

`endif

// File: sv/sdrf_pkg.sv
package sdrf_pkg;

  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned BYTE_W     = 8;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_LINE  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    ptr_t fill;
  } ring_stat_t;

  function automatic ptr_t ring_next(ptr_t p);
    ptr_t n;
    n = p + ptr_t'(1);
    if (p == ptr_t'(FIFO_DEPTH - 1)) begin
      n = '0;
    end
    return n;
  endfunction

  function automatic cnt_t sat_inc(cnt_t c);
    return (c == {CNT_W{1'b1}}) ? c : c + cnt_t'(1);
  endfunction

  // Clamp a fill level to the byte-wide count the host sees.
  function automatic byte_t sat_fill(ptr_t f);
    logic [16:0] w;
    w = 17'(f);
    return (w > 17'd255) ? 8'hFF : w[7:0];
  endfunction

endpackage

// File: sv/serial_dual_ring_fifo_with_error_counts.sv
// Each command runs as follows: start is taken while busy is low, busy is
// high for one cycle while the ring heads are read out of their synchronous
// memories and the step is applied, and in the following cycle done_o pulses
// for exactly one cycle with the result beat. The next command may be started
// in that done cycle. The result beat cannot be held off: sample it while
// done_o is high. The status outputs (tx_armed_o, rx_count_o, tx_done_o and
// the four error counters) hold their value between beats.
module serial_dual_ring_fifo_with_error_counts import sdrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  wr_byte_i,
  input  logic        overrun_flag_i,
  input  logic        framing_flag_i,
  input  logic        noise_flag_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        tx_empty_i,
  input  logic        tx_complete_i,
  output logic        done_o,
  output logic        accepted_o,
  output logic [7:0]  read_byte_o,
  output logic        tx_send_o,
  output logic [7:0]  tx_byte_o,
  output logic        tx_armed_o,
  output logic [7:0]  rx_count_o,
  output logic        tx_done_o,
  output logic [15:0] overrun_count_o,
  output logic [15:0] framing_count_o,
  output logic [15:0] noise_count_o,
  output logic [15:0] dropped_count_o
);

`include "serial_dual_ring_fifo_with_error_counts_defines.svh"

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic accept;

  // Captured command beat.
  logic [1:0] cmd_q;
  byte_t      wr_byte_q;
  logic       ovr_q, frm_q, nse_q, rdy_q, txe_q, txc_q;
  byte_t      rx_byte_q;

  // Ring interfaces.
  ring_ctrl_t tx_ctrl, rx_ctrl;
  ring_stat_t tx_stat, rx_stat;
  byte_t      tx_rdata, rx_rdata;

  // Step results.
  logic  exec, is_wr, is_rd, is_line;
  logic  tx_service;
  logic  armed_q, armed_d;
  cnt_t  ovr_cnt_q, ovr_cnt_d;
  cnt_t  frm_cnt_q, frm_cnt_d;
  cnt_t  nse_cnt_q, nse_cnt_d;
  cnt_t  drop_cnt_q, drop_cnt_d;
  logic  tx_empty_after;
  ptr_t  rx_fill_after;

  logic  done_q, accepted_q, tx_send_q, tx_done_q;
  byte_t read_byte_q, tx_byte_q, rx_count_q;

  assign accept = start && !busy;
  assign busy   = (state_q == ST_EXEC);
  assign exec   = (state_q == ST_EXEC);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the beat while the ring heads come out of memory.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_i;
      wr_byte_q <= wr_byte_i;
      ovr_q     <= overrun_flag_i;
      frm_q     <= framing_flag_i;
      nse_q     <= noise_flag_i;
      rdy_q     <= rx_ready_i;
      rx_byte_q <= rx_byte_i;
      txe_q     <= tx_empty_i;
      txc_q     <= tx_complete_i;
    end
  end

  assign is_wr   = exec && (cmd_q == CMD_WRITE);
  assign is_rd   = exec && (cmd_q == CMD_READ);
  assign is_line = exec && (cmd_q == CMD_LINE);

  // Transmit service runs only on a line event with the transmitter empty and the request armed.
  assign tx_service = is_line && txe_q && armed_q;

  assign tx_ctrl.push = is_wr && !tx_stat.full;
  assign tx_ctrl.pop  = tx_service && !tx_stat.empty;
  assign rx_ctrl.push = is_line && rdy_q && !rx_stat.full;
  assign rx_ctrl.pop  = is_rd && !rx_stat.empty;

  sdrf_ring u_tx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tx_ctrl),
    .wdata_i (wr_byte_q),
    .rdata_o (tx_rdata),
    .stat_o  (tx_stat)
  );

  sdrf_ring u_rx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rx_ctrl),
    .wdata_i (rx_byte_q),
    .rdata_o (rx_rdata),
    .stat_o  (rx_stat)
  );

  always_comb begin
    // Transmit FIFO goes empty when its last entry is sent, and leaves empty on a push.
    tx_empty_after = (tx_stat.empty && !tx_ctrl.push)
                  || (tx_ctrl.pop && (tx_stat.fill == ptr_t'(1)));
    rx_fill_after  = rx_stat.fill + ptr_t'(rx_ctrl.push) - ptr_t'(rx_ctrl.pop);

    armed_d = armed_q;
    if (tx_ctrl.push) begin
      armed_d = 1'b1;
    end
    // Disarm once nothing is left to send.
    if (tx_service && tx_empty_after) begin
      armed_d = 1'b0;
    end

    ovr_cnt_d  = (is_line && ovr_q) ? sat_inc(ovr_cnt_q) : ovr_cnt_q;
    frm_cnt_d  = (is_line && frm_q) ? sat_inc(frm_cnt_q) : frm_cnt_q;
    nse_cnt_d  = (is_line && nse_q) ? sat_inc(nse_cnt_q) : nse_cnt_q;
    drop_cnt_d = (is_line && rdy_q && rx_stat.full) ? sat_inc(drop_cnt_q) : drop_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      armed_q    <= 1'b0;
      ovr_cnt_q  <= '0;
      frm_cnt_q  <= '0;
      nse_cnt_q  <= '0;
      drop_cnt_q <= '0;
      done_q     <= 1'b0;
      tx_done_q  <= 1'b0;
      rx_count_q <= '0;
    end else begin
      state_q    <= state_d;
      armed_q    <= armed_d;
      ovr_cnt_q  <= ovr_cnt_d;
      frm_cnt_q  <= frm_cnt_d;
      nse_cnt_q  <= nse_cnt_d;
      drop_cnt_q <= drop_cnt_d;
      done_q     <= exec;
      if (exec) begin
        tx_done_q  <= tx_empty_after && txc_q;
        rx_count_q <= sat_fill(rx_fill_after);
      end
    end
  end

  // Result beat payload; zero the byte fields when nothing moved.
  always_ff @(posedge clk_i) begin
    if (exec) begin
      accepted_q  <= tx_ctrl.push || rx_ctrl.pop;
      read_byte_q <= rx_ctrl.pop ? rx_rdata : '0;
      tx_send_q   <= tx_ctrl.pop;
      tx_byte_q   <= tx_ctrl.pop ? tx_rdata : '0;
    end
  end

  assign done_o          = done_q;
  assign accepted_o      = accepted_q;
  assign read_byte_o     = read_byte_q;
  assign tx_send_o       = tx_send_q;
  assign tx_byte_o       = tx_byte_q;
  assign tx_armed_o      = armed_q;
  assign rx_count_o      = rx_count_q;
  assign tx_done_o       = tx_done_q;
  assign overrun_count_o = ovr_cnt_q;
  assign framing_count_o = frm_cnt_q;
  assign noise_count_o   = nse_cnt_q;
  assign dropped_count_o = drop_cnt_q;

  `SDRF_ASSERT_NXT(a_accept_then_busy, accept, busy && !done_o)
  `SDRF_ASSERT_NXT(a_exec_then_done, busy, done_o && !busy)
  `SDRF_ASSERT_IMP(a_no_push_when_full, tx_ctrl.push || rx_ctrl.push,
                   !(tx_ctrl.push && tx_stat.full) && !(rx_ctrl.push && rx_stat.full))
  `SDRF_ASSERT_IMP(a_send_not_with_accept, done_o, !(accepted_o && tx_send_o))
  `SDRF_ASSERT_IMP(a_send_leaves_armed_only_if_data, done_o && tx_armed_o, !tx_stat.empty)

endmodule

// File: sv/sdrf_ring.sv
module sdrf_ring import sdrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ring_ctrl_t ctrl_i,
  input  byte_t      wdata_i,
  output byte_t      rdata_o,
  output ring_stat_t stat_o
);

  byte_t mem [FIFO_DEPTH];
  byte_t rdata_q;
  ptr_t  wr_ptr_q, wr_ptr_d;
  ptr_t  rd_ptr_q, rd_ptr_d;
  ptr_t  fill;

  // Read the head entry every cycle; writes land on the tail, which is the head slot only while the ring is empty.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
    rdata_q <= mem[rd_ptr_q];
  end

  always_comb begin
    wr_ptr_d = ctrl_i.push ? ring_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = ctrl_i.pop  ? ring_next(rd_ptr_q) : rd_ptr_q;
    if (wr_ptr_q >= rd_ptr_q) begin
      fill = wr_ptr_q - rd_ptr_q;
    end else begin
      fill = ptr_t'(FIFO_DEPTH - 1) - rd_ptr_q + wr_ptr_q + ptr_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  assign rdata_o      = rdata_q;
  assign stat_o.empty = (wr_ptr_q == rd_ptr_q);
  assign stat_o.full  = (ring_next(wr_ptr_q) == rd_ptr_q);
  assign stat_o.fill  = fill;

endmodule
